// ----- hw/rtl/lwsd_pkg.sv -----
// Shared types and constants for the local window stddev / CCV filter.
// No dependencies; the controller, datapath, top level and testbench import this package.
package lwsd_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MASK_SIDE   = 8;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned STORE_DEPTH = MASK_SIDE * MAX_WIDTH;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);     // store address
  localparam int unsigned CW          = $clog2(MAX_WIDTH);       // column counter
  localparam int unsigned RW          = $clog2(MAX_HEIGHT);      // row counter
  localparam int unsigned LW          = CW + RW;                 // raster index
  localparam int unsigned MPW         = $clog2(MASK_SIDE * MASK_SIDE); // mask bit index
  localparam int unsigned MSW         = $clog2(MASK_SIDE);       // mask col/row counter

  localparam int unsigned CCV_SCALE  = 100;
  localparam int unsigned ROOT_STEPS = 14;
  localparam int unsigned DIV_STEPS  = 35;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    REG_STAT_MODE    = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_MASK_WIDTH   = 3'd3,
    REG_MASK_HEIGHT  = 3'd4,
    REG_MASK_BITS    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_SCAN,
    ST_TAIL,
    ST_MUL,
    ST_DIFF,
    ST_ROOT,
    ST_DIVLD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic push;
    logic init;
    logic scan;
    logic mul;
    logic diff;
    logic root;
    logic divld;
    logic div;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic draining;
    logic emit_ok;
    logic scan_last;
    logic root_last;
    logic div_last;
    logic zero;
    logic mode;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/lwsd_in_if.sv -----
// Input channel: valid/ready with opcode and pixel payload.
// Depends on nothing.
interface lwsd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pixel;

  modport source (output valid, output opcode, output pixel, input ready);
  modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

// ----- hw/rtl/lwsd_out_if.sv -----
// Result channel: valid/ready with filtered value and end-of-frame flag.
// Depends on nothing.
interface lwsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stat_value;
  logic       end_of_frame;

  modport source (output valid, output stat_value, output end_of_frame, input ready);
  modport sink   (input valid, input stat_value, input end_of_frame, output ready);
endinterface

// ----- hw/rtl/lwsd_ctrl.sv -----
// Controller state machine of the filter: sequences store write, window
// scan, arithmetic and result load. Depends on lwsd_pkg.
module lwsd_ctrl
  import lwsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_opcode_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_FLUSH) begin
            if (sts_i.draining) state_d = ST_INIT;
          end else if (!sts_i.draining) begin
            cmd_o.push = 1'b1;
            state_d    = ST_CHECK;
          end
        end
      end
      ST_CHECK: state_d = sts_i.emit_ok ? ST_INIT : ST_IDLE;
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = ST_TAIL;
      end
      ST_TAIL: state_d = ST_MUL;
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        if (sts_i.zero)      state_d = ST_OUT;
        else if (sts_i.mode) state_d = ST_DIVLD;
        else                 state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root = 1'b1;
        if (sts_i.root_last) state_d = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd_o.divld = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/lwsd_dp.sv -----
// Datapath of the filter: config registers, line store, raster counters,
// window accumulators, isqrt and divider iterations, result register.
// Depends on lwsd_pkg.
module lwsd_dp
  import lwsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  pixel_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  stat_value_o,
  output logic        end_of_frame_o
);

  // configuration
  logic        mode_q;
  logic [10:0] imw_q;
  logic [12:0] imh_q;
  logic [3:0]  mw_q, mh_q;
  logic [63:0] mask_q;

  // raster state
  logic [CW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_row_q, out_row_q;
  logic [LW-1:0] in_lin_q, cur_q;
  logic          draining_q;

  // line store
  logic [7:0] store [STORE_DEPTH];
  logic [7:0] rd_q;

  // scan and accumulate
  logic [MSW-1:0] ci_q, rj_q;
  logic [MPW-1:0] b_q;
  logic           pv_q;
  logic [6:0]     n_q;
  logic [13:0]    s1_q;
  logic [21:0]    s2_q;

  // arithmetic
  logic [27:0] p1_q, p2_q, d_q;
  logic [27:0] rv_q, rr_q, rb_q;
  logic [34:0] dvd_q;
  logic [27:0] dsr_q, rem_q;
  logic [5:0]  it_q;

  // result register
  logic       res_valid_q;
  logic [7:0] res_val_q;
  logic       res_eof_q;

  // clamped sizes
  logic [10:0] w;
  logic [12:0] h;
  logic [3:0]  mw, mh, left, up, right, down;

  always_comb begin
    if (imw_q == 11'd0)                   w = 11'd1;
    else if (imw_q > 11'(MAX_WIDTH))      w = 11'(MAX_WIDTH);
    else                                  w = imw_q;
    if (imh_q == 13'd0)                   h = 13'd1;
    else if (imh_q > 13'(MAX_HEIGHT))     h = 13'(MAX_HEIGHT);
    else                                  h = imh_q;
    if (mw_q == 4'd0)                     mw = 4'd1;
    else if (mw_q > 4'(MASK_SIDE))        mw = 4'(MASK_SIDE);
    else                                  mw = mw_q;
    if (mh_q == 4'd0)                     mh = 4'd1;
    else if (mh_q > 4'(MASK_SIDE))        mh = 4'(MASK_SIDE);
    else                                  mh = mh_q;
  end

  assign left  = mw >> 1;
  assign up    = mh >> 1;
  assign right = mw - 4'd1 - left;
  assign down  = mh - 4'd1 - up;

  // emit check: bottom-right corner of the window already stored
  logic [12:0] ry_full, ry;
  logic [10:0] cx_full, cx;
  logic [23:0] chk_lin;

  always_comb begin
    ry_full = {1'b0, out_row_q} + {9'b0, down};
    ry      = (ry_full > h - 13'd1) ? h - 13'd1 : ry_full;
    cx_full = {1'b0, out_col_q} + {7'b0, right};
    cx      = (cx_full > w - 11'd1) ? w - 11'd1 : cx_full;
    chk_lin = 24'(ry[RW-1:0] * w) + {13'b0, cx};
  end

  // window point address
  logic [13:0] l14;
  logic [11:0] k12;
  logic        in_img, used;
  logic [23:0] prod;
  logic [AW-1:0] sa;

  always_comb begin
    l14    = {2'b0, out_row_q} + {11'b0, rj_q} - {10'b0, up};
    k12    = {2'b0, out_col_q} + {9'b0, ci_q} - {8'b0, left};
    in_img = !l14[13] && (l14 < {1'b0, h}) && !k12[11] && (k12 < {1'b0, w});
    used   = mask_q[b_q];
    prod   = l14[12:0] * w;
    sa     = prod[AW-1:0] + {2'b0, k12[10:0]};
  end

  // isqrt step
  logic [28:0] rsum;
  assign rsum = {1'b0, rr_q} + {1'b0, rb_q};

  // divider step
  logic [28:0] trial;
  assign trial = {rem_q, dvd_q[34]};

  logic [7:0] quot_sat;
  assign quot_sat = (|dvd_q[34:8]) ? 8'hFF : dvd_q[7:0];

  logic zero;
  assign zero = (n_q == 7'd0) || (s1_q == 14'd0);

  assign sts_o.draining  = draining_q;
  assign sts_o.emit_ok   = chk_lin <= {2'b0, cur_q};
  assign sts_o.scan_last = ({1'b0, ci_q} == mw - 4'd1) && ({1'b0, rj_q} == mh - 4'd1);
  assign sts_o.root_last = it_q == 6'(ROOT_STEPS - 1);
  assign sts_o.div_last  = it_q == 6'(DIV_STEPS - 1);
  assign sts_o.zero      = zero;
  assign sts_o.mode      = mode_q;
  assign sts_o.out_free  = !res_valid_q || out_ready_i;

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) store[in_lin_q[AW-1:0]] <= pixel_i;
    rd_q <= store[sa];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) cur_q <= in_lin_q;
    if (cmd_i.init) begin
      ci_q <= '0;
      rj_q <= '0;
      b_q  <= '0;
      n_q  <= '0;
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      if (cmd_i.scan) begin
        n_q <= n_q + {6'b0, used};
        b_q <= b_q + 1'b1;
        if ({1'b0, ci_q} == mw - 4'd1) begin
          ci_q <= '0;
          rj_q <= rj_q + 1'b1;
        end else begin
          ci_q <= ci_q + 1'b1;
        end
      end
      if (pv_q) begin
        s1_q <= s1_q + {6'b0, rd_q};
        s2_q <= s2_q + {6'b0, 16'(rd_q) * 16'(rd_q)};
      end
    end
    if (cmd_i.mul) begin
      p1_q <= 28'(n_q) * 28'(s2_q);
      p2_q <= 28'(s1_q) * 28'(s1_q);
    end
    if (cmd_i.diff) begin
      d_q  <= p1_q - p2_q;
      rv_q <= p1_q - p2_q;
      rr_q <= '0;
      rb_q <= 28'h400_0000;
      it_q <= '0;
    end
    if (cmd_i.root) begin
      if ({1'b0, rv_q} >= rsum) begin
        rv_q <= rv_q - rsum[27:0];
        rr_q <= (rr_q >> 1) + rb_q;
      end else begin
        rr_q <= rr_q >> 1;
      end
      rb_q <= rb_q >> 2;
      it_q <= it_q + 6'd1;
    end
    if (cmd_i.divld) begin
      if (mode_q) begin
        dvd_q <= 35'(d_q) * 35'(CCV_SCALE);
        dsr_q <= p2_q;
      end else begin
        dvd_q <= {21'b0, rr_q[13:0]};
        dsr_q <= {21'b0, n_q};
      end
      rem_q <= '0;
      it_q  <= '0;
    end
    if (cmd_i.div) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_q <= 28'(trial - {1'b0, dsr_q});
        dvd_q <= {dvd_q[33:0], 1'b1};
      end else begin
        rem_q <= trial[27:0];
        dvd_q <= {dvd_q[33:0], 1'b0};
      end
      it_q <= it_q + 6'd1;
    end
    if (cmd_i.load) res_val_q <= zero ? 8'd0 : quot_sat;
  end

  // control registers
  logic out_row_end, out_col_end;
  assign out_col_end = ({1'b0, out_col_q} + 11'd1) >= w;
  assign out_row_end = ({1'b0, out_row_q} + 13'd1) >= h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      imw_q       <= 11'd1024;
      imh_q       <= 13'd1024;
      mw_q        <= 4'd3;
      mh_q        <= 4'd3;
      mask_q      <= 64'd511;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_lin_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      draining_q  <= 1'b0;
      pv_q        <= 1'b0;
      res_valid_q <= 1'b0;
      res_eof_q   <= 1'b0;
    end else begin
      pv_q <= cmd_i.scan && used && in_img;
      if (cmd_i.push) begin
        if (({1'b0, in_col_q} + 11'd1) < w) begin
          in_col_q <= in_col_q + 1'b1;
          in_lin_q <= in_lin_q + 1'b1;
        end else begin
          in_col_q <= '0;
          if (({1'b0, in_row_q} + 13'd1) < h) begin
            in_row_q <= in_row_q + 1'b1;
            in_lin_q <= in_lin_q + 1'b1;
          end else begin
            in_row_q   <= '0;
            in_lin_q   <= '0;
            draining_q <= 1'b1;
          end
        end
      end
      if (cmd_i.load) begin
        res_valid_q <= 1'b1;
        res_eof_q   <= out_col_end && out_row_end;
        if (!out_col_end) begin
          out_col_q <= out_col_q + 1'b1;
        end else begin
          out_col_q <= '0;
          if (!out_row_end) begin
            out_row_q <= out_row_q + 1'b1;
          end else begin
            out_row_q  <= '0;
            draining_q <= 1'b0;
          end
        end
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      // config writes restart the frame; the store is kept
      if (cfg_we_i && (cfg_idx_i <= REG_MASK_BITS)) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          REG_STAT_MODE:    mode_q <= cfg_data_i[0];
          REG_IMAGE_WIDTH:  imw_q  <= cfg_data_i[10:0];
          REG_IMAGE_HEIGHT: imh_q  <= cfg_data_i[12:0];
          REG_MASK_WIDTH:   mw_q   <= cfg_data_i[3:0];
          REG_MASK_HEIGHT:  mh_q   <= cfg_data_i[3:0];
          REG_MASK_BITS:    mask_q <= cfg_data_i;
          default:          mode_q <= mode_q;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_lin_q   <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        draining_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = res_valid_q;
  assign stat_value_o   = res_val_q;
  assign end_of_frame_o = res_eof_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!res_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_push_not_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !draining_q)
    else $error("pixel stored while draining");

  a_pv_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> $past(cmd_i.scan))
    else $error("accumulate without a scan issue");

  a_eof_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && out_col_end && out_row_end) |=> (out_row_q == '0 && out_col_q == '0))
    else $error("output counters did not wrap at frame end");

endmodule

// ----- hw/rtl/local_window_stddev_ccv_filter.sv -----
// Top level of the local window stddev / CCV filter.
// Depends on lwsd_pkg, lwsd_in_if, lwsd_out_if, lwsd_ctrl and lwsd_dp.
//
// Pixels arrive in raster order and are kept in an 8K-byte line store. For each
// output pixel the block walks the mask points one per cycle, reading the store,
// summing S1 and S2 over in-image neighbours, then forms n*S2-S1^2 and runs
// either a 14-step bit-pair square root followed by a divide by n (stddev), or a
// divide of 100*(n*S2-S1^2) by S1^2 (CCV, saturated to 255). The divider is a
// restoring unit producing one quotient bit per cycle. When n or S1 is zero
// the root and divide are skipped and the result is zero. Items are handled
// one at a time; a finished result sits in an output register so the next item
// is taken while it waits, and the block stalls only if a second result is due
// before the first is taken. Config writes restart the frame counters but keep
// the store; issue them only while the block is idle.
module local_window_stddev_ccv_filter
  import lwsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lwsd_in_if.sink     pix_i,
  lwsd_out_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencing
  lwsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_opcode_i (pix_i.opcode),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // store, counters, arithmetic, result register
  lwsd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_i        (pix_i.pixel),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .stat_value_o   (res_o.stat_value),
    .end_of_frame_o (res_o.end_of_frame)
  );

  // input transfer happens only in the idle state
  assign pix_i.ready = in_ready;

endmodule

// ----- dv/local_window_stddev_ccv_filter_test.sv -----
// Self-checking testbench for local_window_stddev_ccv_filter.
// Needs lwsd_pkg, lwsd_in_if, lwsd_out_if and the filter RTL; nothing else.
module local_window_stddev_ccv_filter_test;
  import lwsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       op;
    logic [7:0] pix;
  } pix_item_t;

  typedef struct {
    logic [7:0] val;
    logic       eof;
  } stat_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  cfg_idx_e cfg_idx;
  logic [63:0] cfg_data;

  lwsd_in_if  pix ();
  lwsd_out_if res ();

  local_window_stddev_ccv_filter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: a mirror of the block's registers, counters and store.
  logic [7:0]  px_store [STORE_DEPTH];
  int unsigned in_col, in_row, out_col, out_row;
  bit          draining;
  int unsigned cf_mode, cf_w, cf_h, cf_mw, cf_mh;
  logic [63:0] cf_bits;

  pix_item_t pixel_q[$];   // items waiting for the driver
  stat_res_t stat_q[$];    // results predicted, not yet seen

  bit in_took;
  int send_gap, recv_gap, hold_cnt;
  bit held, calm;
  int errors, n_push, n_flush, n_checked, n_phases;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Sum of the in-image neighbours under the mask, then stddev or CCV.
  function automatic logic [7:0] window_stat(int unsigned w, int unsigned h);
    int unsigned mw, mh;
    longint unsigned n, s1, s2, d, q, v;
    int l, k;
    mw = clampu(cf_mw, 1, MASK_SIDE);
    mh = clampu(cf_mh, 1, MASK_SIDE);
    n = 0; s1 = 0; s2 = 0;
    for (int j = 0; j < mh; j++) begin
      for (int i = 0; i < mw; i++) begin
        if (cf_bits[j * mw + i]) begin
          n++;
          l = int'(out_row) + j - int'(mh / 2);
          k = int'(out_col) + i - int'(mw / 2);
          if (l >= 0 && l < int'(h) && k >= 0 && k < int'(w)) begin
            v = px_store[(l * w + k) % STORE_DEPTH];
            s1 += v;
            s2 += v * v;
          end
        end
      end
    end
    if (n == 0 || s1 == 0) return 8'd0;
    d = n * s2 - s1 * s1;
    if (cf_mode == 0) return int_root(d) / n;
    q = (CCV_SCALE * d) / (s1 * s1);
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  function automatic void emit_stat(int unsigned w, int unsigned h);
    stat_res_t r;
    r.val = window_stat(w, h);
    r.eof = 1'b0;
    if (out_col + 1 < w) out_col++;
    else begin
      out_col = 0;
      if (out_row + 1 < h) out_row++;
      else begin
        out_row = 0;
        r.eof = 1'b1;
        draining = 0;
      end
    end
    stat_q.push_back(r);
  endfunction

  function automatic void apply_cfg(cfg_idx_e idx, logic [63:0] d);
    case (idx)
      REG_STAT_MODE:    cf_mode = d[0];
      REG_IMAGE_WIDTH:  cf_w = d[10:0];
      REG_IMAGE_HEIGHT: cf_h = d[12:0];
      REG_MASK_WIDTH:   cf_mw = d[3:0];
      REG_MASK_HEIGHT:  cf_mh = d[3:0];
      REG_MASK_BITS:    cf_bits = d;
      default:          return;
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    draining = 0;
  endfunction

  // One accepted input item: store a pixel or drain one pending output.
  function automatic void take_pixel_item(logic op, logic [7:0] p);
    int unsigned w, h, mw, mh, cur, ry, cx;
    w = clampu(cf_w, 1, MAX_WIDTH);
    h = clampu(cf_h, 1, MAX_HEIGHT);
    mw = clampu(cf_mw, 1, MASK_SIDE);
    mh = clampu(cf_mh, 1, MASK_SIDE);
    if (op == OP_FLUSH) begin
      n_flush++;
      if (draining) emit_stat(w, h);
      return;
    end
    n_push++;
    if (draining) return;
    cur = in_row * w + in_col;
    px_store[cur % STORE_DEPTH] = p;
    if (in_col + 1 < w) in_col++;
    else begin
      in_col = 0;
      if (in_row + 1 < h) in_row++;
      else begin
        in_row = 0;
        draining = 1;
      end
    end
    ry = out_row + (mh - 1 - mh / 2);
    if (ry > h - 1) ry = h - 1;
    cx = out_col + (mw - 1 - mw / 2);
    if (cx > w - 1) cx = w - 1;
    if (ry * w + cx <= cur) emit_stat(w, h);
  endfunction

  // Outputs still owed once the last pixel of a full frame is in.
  function automatic int pending_after_frame(int unsigned w, int unsigned h,
                                             int unsigned mw, int unsigned mh);
    int unsigned o, ry, cx;
    o = 0;
    for (int unsigned c = 0; c < w * h; c++) begin
      ry = o / w + (mh - 1 - mh / 2);
      if (ry > h - 1) ry = h - 1;
      cx = o % w + (mw - 1 - mw / 2);
      if (cx > w - 1) cx = w - 1;
      if (ry * w + cx <= c) o++;
    end
    return w * h - o;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in calm phases.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout at %0t", $realtime);
    $display("*** FAILED ***");
    $finish;
  end

  // Predictor, input monitor and result checker, all on the rising edge.
  always @(posedge clk_i) begin
    stat_res_t e;
    in_took <= pix.valid && pix.ready;
    if (cfg_we) apply_cfg(cfg_idx, cfg_data);
    if (pix.valid && pix.ready) take_pixel_item(pix.opcode, pix.pixel);
    if (res.valid && res.ready) begin
      n_checked++;
      if (stat_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual value %0d eof %0b",
                 $realtime, res.stat_value, res.end_of_frame);
      end else begin
        e = stat_q.pop_front();
        if (res.stat_value !== e.val || res.end_of_frame !== e.eof) begin
          errors++;
          $display("%0t: result mismatch: expected value %0d eof %0b, actual value %0d eof %0b",
                   $realtime, e.val, e.eof, res.stat_value, res.end_of_frame);
        end
      end
    end
  end

  // Pixel driver: holds an item until its transfer, then maybe idles.
  always @(negedge clk_i) begin
    logic v;
    v = pix.valid;
    if (in_took) begin
      void'(pixel_q.pop_front());
      v = 1'b0;
      send_gap = pick_gap();
    end
    if (!v && rst_ni) begin
      if (send_gap > 0) send_gap--;
      else if (pixel_q.size() > 0) begin
        v = 1'b1;
        pix.opcode <= pixel_q[0].op;
        pix.pixel  <= pixel_q[0].pix;
      end
    end
    pix.valid <= v;
  end

  // Result side backpressure; one long hold once results are flowing, so the
  // block fills up and stalls its pixel input.
  always @(negedge clk_i) begin
    if (!held && n_checked >= 40) begin
      held = 1;
      hold_cnt = 700;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      res.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || pix.valid || stat_q.size() != 0);
    // a pixel with no result may still be in flight
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] d);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_pixel(int kind);
    case (kind)
      0: return $urandom_range(0, 255);
      1: return 8'd0;
      2: return $urandom_range(0, 2);
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // One phase: program every register, then a frame (full or cut short).
  task automatic run_frame(int mode, int unsigned w, int unsigned h, int unsigned mw,
                           int unsigned mh, logic [63:0] bits, int kind, int cut);
    int unsigned ew, eh, n_px, pend;
    pix_item_t it;
    wait_idle();
    n_phases++;
    calm = ($urandom_range(0, 4) == 0);
    write_reg(REG_STAT_MODE, mode);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_MASK_WIDTH, mw);
    write_reg(REG_MASK_HEIGHT, mh);
    write_reg(REG_MASK_BITS, bits);
    ew = clampu(w, 1, MAX_WIDTH);
    eh = clampu(h, 1, MAX_HEIGHT);
    // flush before the frame is in: ignored
    if ($urandom_range(0, 3) == 0) begin
      it.op = OP_FLUSH; it.pix = $urandom_range(0, 255);
      pixel_q.push_back(it);
    end
    n_px = (cut > 0) ? cut : ew * eh;
    for (int unsigned c = 0; c < n_px; c++) begin
      it.op = OP_PUSH; it.pix = pick_pixel(kind);
      pixel_q.push_back(it);
    end
    if (cut > 0) return;
    // pixel while draining: ignored
    if ($urandom_range(0, 3) == 0) begin
      it.op = OP_PUSH; it.pix = $urandom_range(0, 255);
      pixel_q.push_back(it);
    end
    pend = pending_after_frame(ew, eh, clampu(mw, 1, MASK_SIDE), clampu(mh, 1, MASK_SIDE));
    if ($urandom_range(0, 4) == 0) pend++;
    for (int unsigned c = 0; c < pend; c++) begin
      it.op = OP_FLUSH; it.pix = $urandom_range(0, 255);
      pixel_q.push_back(it);
    end
  endtask

  initial begin
    int unsigned w, h, mw, mh, kind;
    logic [63:0] bits;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_STAT_MODE;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.opcode = OP_PUSH;
    pix.pixel = '0;
    res.ready = 1'b0;
    in_took = 0; send_gap = 0; recv_gap = 0; hold_cnt = 0; held = 0; calm = 0;
    errors = 0; n_push = 0; n_flush = 0; n_checked = 0; n_phases = 0;
    cf_mode = 0; cf_w = 1024; cf_h = 1024; cf_mw = 3; cf_mh = 3; cf_bits = 64'd511;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; draining = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: 0/255 pixels through a 3x3 full mask in stddev mode, 0..2 pixels
    // in CCV mode, then degenerate sizes (zero, out of range), empty mask and zero frames.
    run_frame(0, 3, 3, 3, 3, 64'd511, 3, 0);
    run_frame(1, 3, 2, 3, 3, 64'd511, 2, 0);
    run_frame(1, 1, 1, 1, 1, 64'd1, 0, 0);
    run_frame(0, 0, 0, 0, 0, '1, 0, 0);
    run_frame(0, 2, 2, 15, 15, '0, 0, 0);
    run_frame(1, 2, 2, 8, 8, '1, 1, 0);
    run_frame(0, 2047, 8191, 8, 8, '1, 0, 12);
    run_frame(1, 1024, 4096, 1, 1, 64'd1, 3, 10);

    // Random frames, small for speed; a few wide ones and a few cut short.
    while (n_push + n_flush < 620) begin
      kind = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      mw = $urandom_range(1, 8);
      mh = $urandom_range(1, 8);
      bits = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: bits = '1;
        1: bits = 64'd1 << $urandom_range(0, 63);
        2: begin w = $urandom_range(30, 64); h = 2; end
        default: ;
      endcase
      run_frame($urandom_range(0, 1), w, h, mw, mh, bits, kind,
                $urandom_range(0, 7) == 0 ? $urandom_range(1, 20) : 0);
    end

    wait_idle();
    $display("covered %0d pushes, %0d flushes, %0d results over %0d frames",
             n_push, n_flush, n_checked, n_phases);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lwsd_pkg.sv
hw/rtl/lwsd_in_if.sv
hw/rtl/lwsd_out_if.sv
hw/rtl/lwsd_ctrl.sv
hw/rtl/lwsd_dp.sv
hw/rtl/local_window_stddev_ccv_filter.sv
dv/local_window_stddev_ccv_filter_test.sv
